/* rtl/dfc_pkg.sv */
package dfc_pkg;

    // Control record that travels with each item down the pipeline
    typedef struct packed {
        logic valid;       // stage holds an item
        logic decided;     // answer settled without the product compare
        logic early_keep;  // that settled answer
    } t_ctl;

endpackage

/* rtl/dfc_geom.sv */
module dfc_geom import dfc_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic signed [COORD_BITS-1:0]   i_left_x,
    input  logic signed [COORD_BITS-1:0]   i_left_y,
    input  logic signed [COORD_BITS-1:0]   i_right_x,
    input  logic signed [COORD_BITS-1:0]   i_right_y,
    input  logic signed [COORD_BITS-1:0]   i_outer_x,
    input  logic signed [COORD_BITS-1:0]   i_outer_y,
    input  logic signed [COORD_BITS-1:0]   i_inner_x,
    input  logic signed [COORD_BITS-1:0]   i_inner_y,
    input  logic                           i_same_vertex,
    output t_ctl                           o_ctl,
    output logic signed [2*COORD_BITS+2:0] o_sa,
    output logic signed [2*COORD_BITS+2:0] o_sb,
    output logic signed [2*COORD_BITS+2:0] o_sc,
    output logic signed [2*COORD_BITS+2:0] o_sd
);

    localparam int DW = COORD_BITS + 1;  // coordinate difference
    localparam int PW = 2 * DW;          // product of two differences
    localparam int SW = PW + 1;          // sum of two products

    // Stage 1: coordinate differences (L-T, R-T, B-T, B-R, B-L)
    logic                 r_v1, r_sv1;
    logic signed [DW-1:0] r_ltx, r_lty, r_rtx, r_rty, r_btx, r_bty;
    logic signed [DW-1:0] r_brx, r_bry, r_blx, r_bly;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sv1 <= i_same_vertex;
        r_ltx <= DW'(i_left_x)  - DW'(i_outer_x);
        r_lty <= DW'(i_left_y)  - DW'(i_outer_y);
        r_rtx <= DW'(i_right_x) - DW'(i_outer_x);
        r_rty <= DW'(i_right_y) - DW'(i_outer_y);
        r_btx <= DW'(i_inner_x) - DW'(i_outer_x);
        r_bty <= DW'(i_inner_y) - DW'(i_outer_y);
        r_brx <= DW'(i_inner_x) - DW'(i_right_x);
        r_bry <= DW'(i_inner_y) - DW'(i_right_y);
        r_blx <= DW'(i_inner_x) - DW'(i_left_x);
        r_bly <= DW'(i_inner_y) - DW'(i_left_y);
    end

    // Stage 2: the twelve products
    logic                 r_v2, r_sv2;
    logic signed [PW-1:0] r_c1a, r_c1b, r_c2a, r_c2b;
    logic signed [PW-1:0] r_saa, r_sab, r_sba, r_sbb;
    logic signed [PW-1:0] r_sca, r_scb, r_sda, r_sdb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sv2 <= r_sv1;
        // cross(L-T, B-T)
        r_c1a <= PW'(r_ltx) * PW'(r_bty);
        r_c1b <= PW'(r_lty) * PW'(r_btx);
        // cross(R-T, B-T)
        r_c2a <= PW'(r_rtx) * PW'(r_bty);
        r_c2b <= PW'(r_rty) * PW'(r_btx);
        // (T-R).(T-L) equals (R-T).(L-T)
        r_saa <= PW'(r_rtx) * PW'(r_ltx);
        r_sab <= PW'(r_rty) * PW'(r_lty);
        // (B-R).(B-L)
        r_sba <= PW'(r_brx) * PW'(r_blx);
        r_sbb <= PW'(r_bry) * PW'(r_bly);
        // cross(T-R, T-L) equals cross(R-T, L-T)
        r_sca <= PW'(r_rtx) * PW'(r_lty);
        r_scb <= PW'(r_rty) * PW'(r_ltx);
        // cross(B-R, B-L)
        r_sda <= PW'(r_brx) * PW'(r_bly);
        r_sdb <= PW'(r_bry) * PW'(r_blx);
    end

    // Stage 3: sums and the early decisions
    logic signed [SW-1:0] n_c1, n_c2, n_sa, n_sb, n_sc, n_sd;
    logic                 n_nonconvex;
    t_ctl                 n_ctl;
    t_ctl                 r_ctl3;
    logic signed [SW-1:0] r_sa, r_sb, r_sc, r_sd;

    always_comb begin
        n_c1 = SW'(r_c1a) - SW'(r_c1b);
        n_c2 = SW'(r_c2a) - SW'(r_c2b);
        n_sa = SW'(r_saa) + SW'(r_sab);
        n_sb = SW'(r_sba) + SW'(r_sbb);
        n_sc = SW'(r_sca) - SW'(r_scb);
        n_sd = SW'(r_sda) - SW'(r_sdb);
        n_nonconvex = n_c1[SW-1] || (!n_c2[SW-1] && (n_c2 != '0));
        n_ctl.valid      = r_v2;
        n_ctl.decided    = r_sv2 || n_nonconvex || (n_sa[SW-1] == n_sb[SW-1]);
        n_ctl.early_keep = r_sv2 || n_nonconvex || (!n_sa[SW-1] && !n_sb[SW-1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3 <= '0;
        end else begin
            r_ctl3 <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sa <= n_sa;
        r_sb <= n_sb;
        r_sc <= n_sc;
        r_sd <= n_sd;
    end

    assign o_ctl = r_ctl3;
    assign o_sa  = r_sa;
    assign o_sb  = r_sb;
    assign o_sc  = r_sc;
    assign o_sd  = r_sd;

    // Valid flag travels exactly three stages
    a_valid_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##3 o_ctl.valid)
        else $error("item lost in geometry stages");

    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid |-> ##3 !o_ctl.valid)
        else $error("item invented in geometry stages");

    // Same vertex always settles as keep
    a_same_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_same_vertex) |-> ##3 (o_ctl.decided && o_ctl.early_keep))
        else $error("same vertex not settled as keep");

endmodule

/* rtl/dfc_cmp.sv */
module dfc_cmp import dfc_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_ctl                           i_ctl,
    input  logic signed [2*COORD_BITS+2:0] i_sa,
    input  logic signed [2*COORD_BITS+2:0] i_sb,
    input  logic signed [2*COORD_BITS+2:0] i_sc,
    input  logic signed [2*COORD_BITS+2:0] i_sd,
    output logic                           o_done,
    output logic                           o_keep
);

    localparam int SW = 2 * COORD_BITS + 3;  // signed sum
    localparam int MW = SW - 1;              // magnitude
    localparam int LO = (MW + 1) / 2;        // low half of an operand
    localparam int HI = MW - LO;             // high half
    localparam int QW = 2 * MW;              // full product

    // Stage 4: magnitudes, pick operands so keep = A*B >= C*D
    logic [MW-1:0] n_msa, n_msb, n_msc, n_msd;
    logic [MW-1:0] r_a, r_b, r_c, r_d;
    t_ctl          r_ctl4;

    always_comb begin
        n_msa = i_sa[SW-1] ? MW'(-i_sa) : MW'(i_sa);
        n_msb = i_sb[SW-1] ? MW'(-i_sb) : MW'(i_sb);
        n_msc = i_sc[SW-1] ? MW'(-i_sc) : MW'(i_sc);
        n_msd = i_sd[SW-1] ? MW'(-i_sd) : MW'(i_sd);
    end

    always_ff @(posedge i_clk) begin
        if (i_sb[SW-1]) begin
            r_a <= n_msa;
            r_b <= n_msd;
            r_c <= n_msc;
            r_d <= n_msb;
        end else begin
            r_a <= n_msc;
            r_b <= n_msb;
            r_c <= n_msa;
            r_d <= n_msd;
        end
    end

    // Stage 5: half-width partial products
    logic [2*LO-1:0]    r_ab_ll, r_cd_ll;
    logic [LO+HI-1:0]   r_ab_lh, r_ab_hl, r_cd_lh, r_cd_hl;
    logic [2*HI-1:0]    r_ab_hh, r_cd_hh;
    t_ctl               r_ctl5;

    always_ff @(posedge i_clk) begin
        r_ab_ll <= (2*LO)'(r_a[LO-1:0])     * (2*LO)'(r_b[LO-1:0]);
        r_ab_lh <= (LO+HI)'(r_a[LO-1:0])    * (LO+HI)'(r_b[MW-1:LO]);
        r_ab_hl <= (LO+HI)'(r_a[MW-1:LO])   * (LO+HI)'(r_b[LO-1:0]);
        r_ab_hh <= (2*HI)'(r_a[MW-1:LO])    * (2*HI)'(r_b[MW-1:LO]);
        r_cd_ll <= (2*LO)'(r_c[LO-1:0])     * (2*LO)'(r_d[LO-1:0]);
        r_cd_lh <= (LO+HI)'(r_c[LO-1:0])    * (LO+HI)'(r_d[MW-1:LO]);
        r_cd_hl <= (LO+HI)'(r_c[MW-1:LO])   * (LO+HI)'(r_d[LO-1:0]);
        r_cd_hh <= (2*HI)'(r_c[MW-1:LO])    * (2*HI)'(r_d[MW-1:LO]);
    end

    // Stage 6: assemble the full products
    logic [QW-1:0] r_pab, r_pcd;
    t_ctl          r_ctl6;

    always_ff @(posedge i_clk) begin
        r_pab <= (QW'(r_ab_hh) << (2*LO)) + ((QW'(r_ab_lh) + QW'(r_ab_hl)) << LO)
               + QW'(r_ab_ll);
        r_pcd <= (QW'(r_cd_hh) << (2*LO)) + ((QW'(r_cd_lh) + QW'(r_cd_hl)) << LO)
               + QW'(r_cd_ll);
    end

    // Stage 7: compare and output register
    logic r_done, r_keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl4 <= '0;
            r_ctl5 <= '0;
            r_ctl6 <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl4 <= i_ctl;
            r_ctl5 <= r_ctl4;
            r_ctl6 <= r_ctl5;
            r_done <= r_ctl6.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_keep <= r_ctl6.decided ? r_ctl6.early_keep : (r_pab >= r_pcd);
    end

    assign o_done = r_done;
    assign o_keep = r_keep;

    // Settled items come out of the compare stages with their settled answer
    a_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.valid && i_ctl.decided) |-> ##4 (o_done && (o_keep == $past(i_ctl.early_keep, 4))))
        else $error("settled answer lost in compare stages");

    a_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.valid |-> ##4 !o_done)
        else $error("result strobe without an item");

endmodule

/* rtl/delaunay_flip_condition_check_top.sv */
// Delaunay flip test, angle-sum form, exact integer arithmetic.
// Pipeline: geometry in 3 stages, then operand select, split multiply,
// product assembly and compare.
// Throughput: one item every cycle; busy is never raised.
// Reset: synchronous active-low i_rst_n clears all valid flags; results
// are strobed for one cycle and cannot be held off by the receiver.
module delaunay_flip_condition_check_top import dfc_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_left_x,
    input  logic signed [COORD_BITS-1:0] i_left_y,
    input  logic signed [COORD_BITS-1:0] i_right_x,
    input  logic signed [COORD_BITS-1:0] i_right_y,
    input  logic signed [COORD_BITS-1:0] i_outer_x,
    input  logic signed [COORD_BITS-1:0] i_outer_y,
    input  logic signed [COORD_BITS-1:0] i_inner_x,
    input  logic signed [COORD_BITS-1:0] i_inner_y,
    input  logic                         i_same_vertex,
    output logic                         o_done,
    output logic                         o_keep_edge
);

    localparam int SW = 2 * COORD_BITS + 3;

    t_ctl                 w_ctl;
    logic signed [SW-1:0] w_sa, w_sb, w_sc, w_sd;

    // Pipeline never stalls
    assign busy = 1'b0;

    dfc_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (start),
        .i_left_x      (i_left_x),
        .i_left_y      (i_left_y),
        .i_right_x     (i_right_x),
        .i_right_y     (i_right_y),
        .i_outer_x     (i_outer_x),
        .i_outer_y     (i_outer_y),
        .i_inner_x     (i_inner_x),
        .i_inner_y     (i_inner_y),
        .i_same_vertex (i_same_vertex),
        .o_ctl         (w_ctl),
        .o_sa          (w_sa),
        .o_sb          (w_sb),
        .o_sc          (w_sc),
        .o_sd          (w_sd)
    );

    dfc_cmp #(
        .COORD_BITS (COORD_BITS)
    ) u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_sa    (w_sa),
        .i_sb    (w_sb),
        .i_sc    (w_sc),
        .i_sd    (w_sd),
        .o_done  (o_done),
        .o_keep  (o_keep_edge)
    );

endmodule

/* verif/tb_delaunay_flip_condition_check_top.sv */
`timescale 1ns / 1ps

module tb_delaunay_flip_condition_check_top;

    localparam int COORD_BITS   = 16;
    localparam int C_MAX        = 2 ** (COORD_BITS - 1) - 1;
    localparam int C_MIN        = -C_MAX - 1;
    localparam int PIPE_LATENCY = 7;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1650;
    localparam real TWO_PI      = 6.283185307179586;

    // One quadrilateral test: edge L-R, outer point T, inner point B
    typedef struct packed {
        logic signed [COORD_BITS-1:0] left_x;
        logic signed [COORD_BITS-1:0] left_y;
        logic signed [COORD_BITS-1:0] right_x;
        logic signed [COORD_BITS-1:0] right_y;
        logic signed [COORD_BITS-1:0] outer_x;
        logic signed [COORD_BITS-1:0] outer_y;
        logic signed [COORD_BITS-1:0] inner_x;
        logic signed [COORD_BITS-1:0] inner_y;
        logic                         same_vertex;
    } t_quad;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic signed [COORD_BITS-1:0] i_left_x = '0;
    logic signed [COORD_BITS-1:0] i_left_y = '0;
    logic signed [COORD_BITS-1:0] i_right_x = '0;
    logic signed [COORD_BITS-1:0] i_right_y = '0;
    logic signed [COORD_BITS-1:0] i_outer_x = '0;
    logic signed [COORD_BITS-1:0] i_outer_y = '0;
    logic signed [COORD_BITS-1:0] i_inner_x = '0;
    logic signed [COORD_BITS-1:0] i_inner_y = '0;
    logic                         i_same_vertex = 1'b0;
    logic                         o_done;
    logic                         o_keep_edge;

    t_quad pending_quads[$];
    bit    keep_edge_q[$];
    t_quad next_quad;
    int    burst_left = 0;
    int    gap_left = 0;
    int    fail_count = 0;
    int    result_count = 0;
    int    stall_cycles = 0;
    bit    want_keep;

    delaunay_flip_condition_check_top #(
        .COORD_BITS(COORD_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_left_x      (i_left_x),
        .i_left_y      (i_left_y),
        .i_right_x     (i_right_x),
        .i_right_y     (i_right_y),
        .i_outer_x     (i_outer_x),
        .i_outer_y     (i_outer_y),
        .i_inner_x     (i_inner_x),
        .i_inner_y     (i_inner_y),
        .i_same_vertex (i_same_vertex),
        .o_done        (o_done),
        .o_keep_edge   (o_keep_edge)
    );

    always #1 i_clk = ~i_clk;

    // Saturate an integer to the coordinate range
    function automatic logic signed [COORD_BITS-1:0] to_coord(int v);
        if (v > C_MAX) return C_MAX[COORD_BITS-1:0];
        if (v < C_MIN) return C_MIN[COORD_BITS-1:0];
        return v[COORD_BITS-1:0];
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rand_coord(int lo, int hi);
        int span;
        span = hi - lo;
        return to_coord(lo + int'($urandom_range(0, span)));
    endfunction

    // Empty-circle decision in angle-sum form, exact integer math
    function automatic bit keep_edge_of(t_quad q);
        longint lx, ly, rx, ry, tx, ty, bx, by;
        longint cr_l, cr_r, sa, sb, sc, sd;
        logic signed [127:0] w_sa, w_sb, w_sc, w_sd, angle_sum;
        lx = signed'(q.left_x);
        ly = signed'(q.left_y);
        rx = signed'(q.right_x);
        ry = signed'(q.right_y);
        tx = signed'(q.outer_x);
        ty = signed'(q.outer_y);
        bx = signed'(q.inner_x);
        by = signed'(q.inner_y);
        if (q.same_vertex) return 1'b1;
        // reflex corner: quad is not convex, flip impossible
        cr_l = (lx - tx) * (by - ty) - (ly - ty) * (bx - tx);
        cr_r = (rx - tx) * (by - ty) - (ry - ty) * (bx - tx);
        if (cr_l < 0 || cr_r > 0) return 1'b1;
        sa = (tx - rx) * (tx - lx) + (ty - ry) * (ty - ly);
        sb = (bx - rx) * (bx - lx) + (by - ry) * (by - ly);
        if (sa >= 0 && sb >= 0) return 1'b1;
        if (sa < 0 && sb < 0) return 1'b0;
        // mixed angles: sign of sin(alpha + beta) scaled
        sc = (tx - rx) * (ty - ly) - (ty - ry) * (tx - lx);
        sd = (bx - rx) * (by - ly) - (by - ry) * (bx - lx);
        if (sc < 0) sc = -sc;
        if (sd < 0) sd = -sd;
        w_sa = sa;
        w_sb = sb;
        w_sc = sc;
        w_sd = sd;
        angle_sum = w_sc * w_sb + w_sa * w_sd;
        return (angle_sum >= 0);
    endfunction

    task automatic add_quad(int lx, int ly, int rx, int ry, int tx, int ty,
                            int bx, int by, bit sv);
        t_quad q;
        q.left_x      = to_coord(lx);
        q.left_y      = to_coord(ly);
        q.right_x     = to_coord(rx);
        q.right_y     = to_coord(ry);
        q.outer_x     = to_coord(tx);
        q.outer_y     = to_coord(ty);
        q.inner_x     = to_coord(bx);
        q.inner_y     = to_coord(by);
        q.same_vertex = sv;
        pending_quads.insert(pending_quads.size(), q);
    endtask

    // Driver: bursts of items with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end else if (pending_quads.size() != 0) begin
                next_quad = pending_quads.pop_front();
                i_left_x      <= next_quad.left_x;
                i_left_y      <= next_quad.left_y;
                i_right_x     <= next_quad.right_x;
                i_right_y     <= next_quad.right_y;
                i_outer_x     <= next_quad.outer_x;
                i_outer_y     <= next_quad.outer_y;
                i_inner_x     <= next_quad.inner_x;
                i_inner_y     <= next_quad.inner_y;
                i_same_vertex <= next_quad.same_vertex;
                start         <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check results in order, predict accepted items, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                result_count++;
                if (keep_edge_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: result %0d with nothing expected, keep_edge=%0b",
                                 result_count, o_keep_edge);
                end else begin
                    want_keep = keep_edge_q.pop_front();
                    if (o_keep_edge !== want_keep) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("ERROR: result %0d keep_edge expected %0b got %0b",
                                     result_count, want_keep, o_keep_edge);
                    end
                end
            end
            if (start && !busy)
                keep_edge_q.insert(keep_edge_q.size(), keep_edge_of({i_left_x, i_left_y,
                    i_right_x, i_right_y, i_outer_x, i_outer_y, i_inner_x, i_inner_y,
                    i_same_vertex}));
            if ((start && !busy) || o_done) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        int    parts[4];
        int    part_sum, jitter;
        real   cx, cy, rad, ang0, acc;
        int    px[4], py[4];
        t_quad q;

        // same vertex overrides everything, even a flip geometry
        add_quad(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1);
        add_quad(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1);
        add_quad(-1000, 0, 1000, 0, 0, 10, 0, -10, 1'b1);
        // degenerate: coincident and collinear points
        add_quad(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_quad(5, 5, 5, 5, 5, 5, 5, 5, 1'b0);
        add_quad(-30000, 0, 0, 0, 30000, 0, 12, 0, 1'b0);
        add_quad(-1, -1, 1, 1, 0, 0, 0, 0, 1'b0);
        // extreme corners, cocircular squares
        add_quad(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, 1'b0);
        add_quad(C_MIN, 0, C_MAX, 0, 0, C_MAX, 0, C_MIN, 1'b0);
        add_quad(C_MAX, 0, C_MIN, 0, 0, C_MIN, 0, C_MAX, 1'b0);
        add_quad(C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, 1'b0);
        add_quad(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, 1'b0);
        // both obtuse, both acute
        add_quad(-1000, 0, 1000, 0, 0, 10, 0, -10, 1'b0);
        add_quad(-10, 0, 10, 0, 0, 1000, 0, -1000, 1'b0);
        // mixed angles: on, inside and outside the circle, both signs
        add_quad(-100, 0, 100, 0, 0, 10, 0, -1000, 1'b0);
        add_quad(-100, 0, 100, 0, 0, 10, 0, -999, 1'b0);
        add_quad(-100, 0, 100, 0, 0, 10, 0, -1001, 1'b0);
        add_quad(-100, 0, 100, 0, 0, 1000, 0, -10, 1'b0);
        add_quad(-100, 0, 100, 0, 0, 999, 0, -10, 1'b0);
        // not convex, reflex at each end of the edge
        add_quad(-1000, 0, 1000, 0, 0, -10, 0, 10, 1'b0);
        add_quad(-1000, 0, 1000, 0, 0, 10, 3000, -10, 1'b0);

        // Random part: mostly near-cocircular convex quads
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    q.left_x  = rand_coord(C_MIN, C_MAX);
                    q.left_y  = rand_coord(C_MIN, C_MAX);
                    q.right_x = rand_coord(C_MIN, C_MAX);
                    q.right_y = rand_coord(C_MIN, C_MAX);
                    q.outer_x = rand_coord(C_MIN, C_MAX);
                    q.outer_y = rand_coord(C_MIN, C_MAX);
                    q.inner_x = rand_coord(C_MIN, C_MAX);
                    q.inner_y = rand_coord(C_MIN, C_MAX);
                end
                2, 3: begin
                    q.left_x  = rand_coord(-8, 8);
                    q.left_y  = rand_coord(-8, 8);
                    q.right_x = rand_coord(-8, 8);
                    q.right_y = rand_coord(-8, 8);
                    q.outer_x = rand_coord(-8, 8);
                    q.outer_y = rand_coord(-8, 8);
                    q.inner_x = rand_coord(-8, 8);
                    q.inner_y = rand_coord(-8, 8);
                end
                default: begin
                    // L, B, R, T counterclockwise on one circle
                    rad  = $urandom_range(0, 1) ? $urandom_range(2, 200)
                                                : $urandom_range(200, 28000);
                    cx   = int'($urandom_range(0, 8000)) - 4000;
                    cy   = int'($urandom_range(0, 8000)) - 4000;
                    ang0 = TWO_PI * $urandom_range(0, 9999) / 10000.0;
                    part_sum = 0;
                    for (int k = 0; k < 4; k++) begin
                        parts[k] = $urandom_range(1, 1000);
                        part_sum += parts[k];
                    end
                    acc = ang0;
                    for (int k = 0; k < 4; k++) begin
                        px[k] = int'(cx + rad * $cos(acc));
                        py[k] = int'(cy + rad * $sin(acc));
                        acc   = acc + TWO_PI * parts[k] / part_sum;
                    end
                    jitter = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 2)) - 1 : 0;
                    q.left_x  = to_coord(px[0]);
                    q.left_y  = to_coord(py[0]);
                    q.inner_x = to_coord(px[1]);
                    q.inner_y = to_coord(py[1]);
                    q.right_x = to_coord(px[2]);
                    q.right_y = to_coord(py[2]);
                    q.outer_x = to_coord(px[3] + jitter);
                    q.outer_y = to_coord(py[3] - jitter);
                    // opposite orientation now and then
                    if ($urandom_range(0, 7) == 0) begin
                        q.outer_x = to_coord(px[1]);
                        q.outer_y = to_coord(py[1]);
                        q.inner_x = to_coord(px[3]);
                        q.inner_y = to_coord(py[3]);
                    end
                end
            endcase
            q.same_vertex = ($urandom_range(0, 15) == 0);
            pending_quads.insert(pending_quads.size(), q);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_quads.size() != 0 || start) @(posedge i_clk);
        while (keep_edge_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY * 4) @(posedge i_clk);

        if (fail_count == 0 && keep_edge_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* delaunay_flip_condition_check_top.f */
rtl/dfc_pkg.sv
rtl/dfc_geom.sv
rtl/dfc_cmp.sv
rtl/delaunay_flip_condition_check_top.sv
verif/tb_delaunay_flip_condition_check_top.sv
